// ===== rtl/core/rlbt_pkg.sv =====
package rlbt_pkg;

    // Float32 field masks and constants
    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] EXP_MASK  = 32'h7f80_0000;
    localparam logic [31:0] MANT_MASK = 32'h007f_ffff;
    localparam logic [31:0] SIX_BITS  = 32'h40c0_0000;
    localparam logic [31:0] SEED_STEP = 32'd3;
    localparam logic [4:0]  DEFAULT_W = 5'd12;

    // Register reset values
    localparam logic [4:0]  RST_WINDOW    = 5'd12;
    localparam logic [4:0]  RST_TAG_BITS  = 5'd1;
    localparam logic [30:0] RST_TAG_VALUE = 31'd1;
    localparam logic [31:0] RST_INCREMENT = 32'd3;
    localparam logic        RST_PATCH_POS = 1'b1;
    localparam logic [30:0] RST_SEED      = 31'd0;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_RELU   = 2'd0,
        OP_RELU6  = 2'd1,
        OP_RESEED = 2'd2
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW    = 3'd0,
        REG_TAG_BITS  = 3'd1,
        REG_TAG_VALUE = 3'd2,
        REG_INCREMENT = 3'd3,
        REG_PATCH_POS = 3'd4,
        REG_SEED      = 3'd5
    } reg_idx_t;

    // Effective window settings derived from the registers
    typedef struct packed {
        logic [31:0] win_mask;
        logic [31:0] pay_mask;
        logic [31:0] tag_field;
        logic [31:0] increment;
        logic        patch_pos;
        logic [31:0] seed_load;
    } cfg_t;

endpackage

// ===== rtl/core/relu_low_bit_tag_writeback.sv =====
// An accepted beat passes through the input register and then the result register before its result shows on m_tdata.
// Throughput: one beat per cycle; the input and result registers form a pipeline
// that stalls only when the result register is full and m_tready is low.
// The seed counter updates only as an item leaves the input register: on a reseed or when it supplies a payload.
// Reset (aresetn low, synchronous) empties both stages, loads the register defaults
// and clears the seed counter.
module relu_low_bit_tag_writeback (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,  // input_value[31:0], previous_output[63:32]
    input  logic [rlbt_pkg::OP_W-1:0]     s_tuser,  // operation[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // result_value[31:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rlbt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rlbt_pkg::DATA_W-1:0]   cfg_data
);
    import rlbt_pkg::*;

    cfg_t        cfg;

    logic            in_valid_reg;
    logic [OP_W-1:0] op_reg;
    logic [31:0]     x_reg;
    logic [31:0]     old_reg;
    logic            out_valid_reg;
    logic [31:0]     result_reg;
    logic [31:0]     counter_reg;
    logic [31:0]     counter_next;

    logic [31:0]     result;
    logic            use_counter;
    logic            advance;

    rlbt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlbt_datapath u_dp (
        .cfg         (cfg),
        .op          (op_reg),
        .x           (x_reg),
        .old         (old_reg),
        .counter     (counter_reg),
        .result      (result),
        .use_counter (use_counter)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // Reload on reseed, step when the counter supplies a payload
    always_comb begin
        counter_next = counter_reg;
        if (advance) begin
            if (op_reg == OP_RESEED) begin
                counter_next = cfg.seed_load;
            end else if (use_counter) begin
                counter_next = counter_reg + SEED_STEP;
            end
        end
    end

    // Pipeline control and seed counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            counter_reg   <= 32'd0;
        end else begin
            counter_reg <= counter_next;
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the input beat and the finished result
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tuser;
            x_reg   <= s_tdata[31:0];
            old_reg <= s_tdata[63:32];
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    // A reseed loads the masked start value and returns zero
    a_reseed_load: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && op_reg == OP_RESEED |=> counter_reg == $past(cfg.seed_load)
            && result_reg == 32'd0)
        else $error("reseed did not load counter or returned nonzero");

    // The counter moves only when an item leaves the input register
    a_counter_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> counter_reg == $past(counter_reg))
        else $error("seed counter changed without an item");

    // A stalled input register keeps its item
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(x_reg)
            && $stable(old_reg) && $stable(op_reg))
        else $error("stalled input item was lost");

    // A held result is not overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(result_reg))
        else $error("pending result overwritten");

    // An empty input register always takes a beat
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input blocked while input register empty");

endmodule

// ===== rtl/core/rlbt_cfg.sv =====
module rlbt_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rlbt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rlbt_pkg::DATA_W-1:0]   cfg_data,
    output rlbt_pkg::cfg_t                cfg
);
    import rlbt_pkg::*;

    logic [4:0]  window_reg;
    logic [4:0]  tag_bits_reg;
    logic [30:0] tag_value_reg;
    logic [31:0] increment_reg;
    logic        patch_pos_reg;
    logic [30:0] seed_reg;

    logic [4:0]  eff_w;
    logic [4:0]  eff_t;
    logic [4:0]  pay_w;
    logic [31:0] pay_mask;
    logic [31:0] tag_mask;

    assign cfg_ready = 1'b1;

    // Take register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= RST_WINDOW;
            tag_bits_reg  <= RST_TAG_BITS;
            tag_value_reg <= RST_TAG_VALUE;
            increment_reg <= RST_INCREMENT;
            patch_pos_reg <= RST_PATCH_POS;
            seed_reg      <= RST_SEED;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_WINDOW:    window_reg    <= cfg_data[4:0];
                REG_TAG_BITS:  tag_bits_reg  <= cfg_data[4:0];
                REG_TAG_VALUE: tag_value_reg <= cfg_data[30:0];
                REG_INCREMENT: increment_reg <= cfg_data;
                REG_PATCH_POS: patch_pos_reg <= cfg_data[0];
                REG_SEED:      seed_reg      <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Resolve window and tag widths; an empty window falls back to the default,
    // a missing or oversized tag shrinks to one bit
    always_comb begin
        eff_w    = (window_reg == 5'd0) ? DEFAULT_W : window_reg;
        eff_t    = (tag_bits_reg == 5'd0 || tag_bits_reg > eff_w) ? 5'd1 : tag_bits_reg;
        pay_w    = eff_w - eff_t;
        pay_mask = (32'd1 << pay_w) - 32'd1;
        tag_mask = (32'd1 << eff_t) - 32'd1;

        cfg.win_mask  = (32'd1 << eff_w) - 32'd1;
        cfg.pay_mask  = pay_mask;
        cfg.tag_field = (({1'b0, tag_value_reg}) & tag_mask) << pay_w;
        cfg.increment = increment_reg;
        cfg.patch_pos = patch_pos_reg;
        cfg.seed_load = {1'b0, seed_reg} & pay_mask;
    end

endmodule

// ===== rtl/core/rlbt_datapath.sv =====
module rlbt_datapath (
    input  rlbt_pkg::cfg_t                cfg,
    input  logic [rlbt_pkg::OP_W-1:0]     op,
    input  logic [31:0]                   x,
    input  logic [31:0]                   old,
    input  logic [31:0]                   counter,
    output logic [31:0]                   result,
    output logic                          use_counter
);
    import rlbt_pkg::*;

    logic [31:0] x0;
    logic        x0_nan;
    logic        x_nan;
    logic [31:0] relu_r;
    logic [31:0] relu6_r;
    logic [31:0] base;
    logic        do_patch;
    logic        carries_tag;
    logic [31:0] payload;
    logic [31:0] patched;

    always_comb begin
        // Fold minus zero before the NaN test
        x0     = (x == SIGN_BIT) ? 32'd0 : x;
        x0_nan = ((x0 & EXP_MASK) == EXP_MASK) && ((x0 & MANT_MASK) != 32'd0);
        x_nan  = ((x & EXP_MASK) == EXP_MASK) && ((x & MANT_MASK) != 32'd0);

        relu_r = x0[31] ? 32'd0 : x0;
        if (x_nan || x[31] || x == 32'd0) begin
            relu6_r = 32'd0;
        end else begin
            relu6_r = (x > SIX_BITS) ? SIX_BITS : x;
        end

        // Select the unpatched value and whether it gets a window
        base     = 32'd0;
        do_patch = 1'b0;
        result   = 32'd0;
        case (op)
            OP_RELU: begin
                base     = relu_r;
                do_patch = !x0_nan && (cfg.patch_pos || relu_r == 32'd0);
                result   = x0_nan ? x0 : relu_r;
            end
            OP_RELU6: begin
                base     = relu6_r;
                do_patch = (relu6_r == 32'd0);
                result   = relu6_r;
            end
            default: ;
        endcase

        // Reuse the old payload when the old word already carries the tag
        if (base == 32'd0) begin
            carries_tag = ((old & ~cfg.win_mask) == 32'd0)
                        && ((old & ~cfg.pay_mask) == cfg.tag_field);
        end else begin
            carries_tag = ((old & cfg.win_mask & ~cfg.pay_mask) == cfg.tag_field);
        end
        payload = carries_tag ? (old & cfg.pay_mask) : (counter & cfg.pay_mask);
        patched = (base & ~cfg.win_mask) | cfg.tag_field
                | ((payload + cfg.increment) & cfg.pay_mask);

        use_counter = do_patch && !carries_tag;
        if (do_patch) begin
            result = patched;
        end
    end

endmodule

// ===== tb/tb_relu_low_bit_tag_writeback.sv =====
module tb_relu_low_bit_tag_writeback;
    import rlbt_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         PHASES      = 12;
    localparam int         PHASE_BEATS = 150;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_EVERY4,
        RX_HALVES
    } rx_mode_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata   = '0;  // input_value[31:0], previous_output[63:32]
    logic [OP_W-1:0]     s_tuser   = '0;  // operation[1:0]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;         // result_value[31:0]
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [DATA_W-1:0]   cfg_data  = '0;

    // Predictor copy of the registers and the seed counter
    logic [4:0]  win_bits;
    logic [4:0]  tag_bits;
    logic [30:0] tag_val;
    logic [31:0] pay_inc;
    logic        patch_pos;
    logic [30:0] seed_start_r;
    logic [31:0] seed_ctr;

    logic [31:0] expected_words[$];

    int mismatch_count = 0;
    int beats_sent     = 0;
    int words_checked  = 0;
    int reg_writes     = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;
    int op_seen[4]     = '{0, 0, 0, 0};

    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    int       rx_phase = 0;

    relu_low_bit_tag_writeback DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Window geometry from the current register copy
    function automatic logic [31:0] low_ones(input int n);
        return (n >= 32) ? 32'hffff_ffff : ((32'h1 << n) - 32'h1);
    endfunction

    function automatic int win_width();
        return (win_bits == 5'd0) ? int'(DEFAULT_W) : int'(win_bits);
    endfunction

    function automatic int tag_width();
        int w;
        w = win_width();
        return (tag_bits == 5'd0 || int'(tag_bits) > w) ? 1 : int'(tag_bits);
    endfunction

    function automatic int payload_width();
        return win_width() - tag_width();
    endfunction

    function automatic logic [31:0] tag_word();
        return ({1'b0, tag_val} & low_ones(tag_width())) << payload_width();
    endfunction

    function automatic logic is_nan_bits(input logic [31:0] b);
        return ((b & EXP_MASK) == EXP_MASK) && ((b & MANT_MASK) != 32'h0);
    endfunction

    // Overwrite the low window with tag and incremented payload
    function automatic logic [31:0] apply_window(input logic [31:0] base, input logic [31:0] old);
        logic [31:0] pm;
        logic [31:0] lm;
        logic [31:0] tf;
        logic [31:0] p;
        logic        carries_tag;
        pm = low_ones(payload_width());
        lm = low_ones(win_width());
        tf = tag_word();
        if (base == 32'h0) begin
            carries_tag = ((old & ~lm) == 32'h0) && ((old & ~pm) == tf);
        end else begin
            carries_tag = ((old & lm & ~pm) == tf);
        end
        if (carries_tag) begin
            p = old & pm;
        end else begin
            p = seed_ctr & pm;
            seed_ctr = seed_ctr + SEED_STEP;
        end
        return (base & ~lm) | tf | ((p + pay_inc) & pm);
    endfunction

    function automatic logic [31:0] predict_writeback(input logic [1:0] op,
                                                      input logic [31:0] x_in,
                                                      input logic [31:0] old);
        logic [31:0] x;
        logic [31:0] r;
        x = x_in;
        r = 32'h0;
        case (op)
            OP_RELU: begin
                if (x == SIGN_BIT) x = 32'h0;
                if (is_nan_bits(x)) begin
                    r = x;
                end else begin
                    r = x[31] ? 32'h0 : x;
                    if (patch_pos || r == 32'h0) r = apply_window(r, old);
                end
            end
            OP_RELU6: begin
                if (is_nan_bits(x) || x[31] || x == 32'h0) r = 32'h0;
                else r = (x > SIX_BITS) ? SIX_BITS : x;
                if (r == 32'h0) r = apply_window(32'h0, old);
            end
            OP_RESEED: begin
                seed_ctr = {1'b0, seed_start_r} & low_ones(payload_width());
            end
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s at result %0d: expected %h, got %h",
                     what, words_checked, want, got);
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin : check_results
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                flag_mismatch("unexpected beat", 32'hx, m_tdata);
            end else begin
                want = expected_words.pop_front();
                if (m_tdata !== want) flag_mismatch("result_value", want, m_tdata);
                words_checked++;
            end
        end
    end

    // Receiver backpressure: switch between randomly chosen stall patterns
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 4));
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready = 1'b1;
            RX_COIN:   m_tready = 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready = ($urandom_range(0, 4) == 0);
            RX_EVERY4: m_tready = ((rx_phase % 4) != 3);
            default:   m_tready = ((rx_phase % 16) < 8);
        endcase
        rx_phase++;
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Send one beat; bursts of random length separated by random gaps
    task automatic send_beat(input logic [1:0] op, input logic [31:0] x, input logic [31:0] old);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 20);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {old, x};
        s_tuser  = op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_words.push_back(predict_writeback(op, x, old));
        op_seen[op]++;
        beats_sent++;
        burst_left--;
    endtask

    // Hold the sender until every expected result has drained
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_registers(input logic [4:0] w, input logic [4:0] t,
                                 input logic [30:0] tv, input logic [31:0] inc,
                                 input logic pp, input logic [30:0] seed);
        logic [31:0] vals[6];
        reg_idx_t    idx;
        vals[0] = {27'h0, w};
        vals[1] = {27'h0, t};
        vals[2] = {1'b0, tv};
        vals[3] = inc;
        vals[4] = {31'h0, pp};
        vals[5] = {1'b0, seed};
        wait_idle();
        for (int i = 0; i < 6; i++) begin
            idx = reg_idx_t'(i);
            @(negedge aclk);
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx)
                REG_WINDOW:    win_bits     = vals[i][4:0];
                REG_TAG_BITS:  tag_bits     = vals[i][4:0];
                REG_TAG_VALUE: tag_val      = vals[i][30:0];
                REG_INCREMENT: pay_inc      = vals[i];
                REG_PATCH_POS: patch_pos    = vals[i][0];
                REG_SEED:      seed_start_r = vals[i][30:0];
                default: ;
            endcase
            reg_writes++;
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Reset defaults: sign, NaN, infinity, clamp and tag-source corners
    task automatic test_default_corners();
        send_beat(OP_RELU,   32'h0000_0000, 32'h0000_0000);
        send_beat(OP_RELU,   32'h8000_0000, 32'h0000_0855);
        send_beat(OP_RELU,   32'hbf80_0000, 32'h1234_5678);
        send_beat(OP_RELU,   32'h7fc0_0000, 32'h0000_0000);
        send_beat(OP_RELU,   32'hffc0_0001, 32'hffff_ffff);
        send_beat(OP_RELU,   32'h7f80_0000, 32'h0000_0000);
        send_beat(OP_RELU,   32'hff80_0000, 32'h0000_0855);
        send_beat(OP_RELU,   32'h7f7f_ffff, 32'h0000_0000);
        send_beat(OP_RELU,   32'h0000_0001, 32'habcd_5855);
        send_beat(OP_RELU,   32'h3f80_0000, 32'hffff_ffff);
        send_beat(OP_RELU6,  32'h40c0_0000, 32'h0000_0000);
        send_beat(OP_RELU6,  32'h40e0_0000, 32'h0000_0000);
        send_beat(OP_RELU6,  32'h40a0_0000, 32'h0000_0000);
        send_beat(OP_RELU6,  32'h7f80_0000, 32'h0000_0000);
        send_beat(OP_RELU6,  32'h7fff_ffff, 32'h0000_0fff);
        send_beat(OP_RELU6,  32'h0000_0000, 32'h0000_0855);
        send_beat(OP_RELU6,  32'hc000_0000, 32'h0000_0fff);
        send_beat(OP_RESEED, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(OP_RELU,   32'h0000_0000, 32'h0000_0000);
    endtask

    // Register corners: zero window, zero and oversized tag, widest and narrowest window
    task automatic test_register_extremes();
        set_registers(5'd0, 5'd0, 31'h7fff_ffff, 32'hffff_ffff, 1'b0, 31'h7fff_ffff);
        send_beat(OP_RESEED, 32'h0, 32'h0);
        send_beat(OP_RELU,   32'h3f80_0000, 32'h0);
        send_beat(OP_RELU,   32'h0000_0000, 32'h0);
        set_registers(5'd5, 5'd9, 31'd3, 32'd1, 1'b1, 31'h15);
        send_beat(OP_RESEED, 32'h0, 32'h0);
        send_beat(OP_RELU,   32'h3f80_0000, 32'h0);
        send_beat(OP_RELU,   32'h8000_0000, 32'h0000_0011);
        set_registers(5'd31, 5'd31, 31'h7fff_ffff, 32'h0, 1'b1, 31'h0);
        send_beat(OP_RELU,   32'h7f80_0000, 32'h5a5a_a5a5);
        send_beat(OP_RELU6,  32'h0000_0000, 32'h7fff_ffff);
        set_registers(5'd1, 5'd1, 31'h0, 32'hffff_ffff, 1'b1, 31'h7fff_ffff);
        send_beat(OP_RELU,   32'h0000_0005, 32'h0);
        send_beat(OP_RESEED, 32'h0, 32'h0);
    endtask

    task automatic random_settings();
        logic [4:0]  w;
        logic [4:0]  t;
        logic [30:0] tv;
        logic [31:0] inc;
        logic [30:0] seed;
        int          ew;
        case ($urandom_range(0, 5))
            0:       w = 5'd0;
            1:       w = 5'd1;
            2:       w = 5'd31;
            3:       w = 5'd12;
            default: w = 5'($urandom_range(2, 30));
        endcase
        ew = (w == 5'd0) ? int'(DEFAULT_W) : int'(w);
        case ($urandom_range(0, 5))
            0:       t = 5'd0;
            1:       t = 5'd1;
            2:       t = 5'(ew);
            3:       t = (ew < 31) ? 5'(ew + 1) : 5'd31;
            4:       t = 5'd31;
            default: t = 5'($urandom_range(1, ew));
        endcase
        case ($urandom_range(0, 3))
            0:       tv = 31'h0;
            1:       tv = 31'h7fff_ffff;
            2:       tv = 31'($urandom_range(0, 7));
            default: tv = 31'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       inc = 32'h0;
            1:       inc = 32'hffff_ffff;
            2:       inc = $urandom_range(0, 15);
            default: inc = $urandom;
        endcase
        case ($urandom_range(0, 2))
            0:       seed = 31'h0;
            1:       seed = 31'h7fff_ffff;
            default: seed = 31'($urandom);
        endcase
        set_registers(w, t, tv, inc, 1'($urandom_range(0, 1)), seed);
    endtask

    // Mostly well-formed values; old words often carry the current tag
    task automatic random_beat();
        logic [1:0]  op;
        logic [31:0] x;
        logic [31:0] old;
        logic [31:0] pm;
        logic [31:0] lm;
        int          pick;
        pm = low_ones(payload_width());
        lm = low_ones(win_width());
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = OP_RELU;
        else if (pick < 85) op = OP_RELU6;
        else if (pick < 93) op = OP_RESEED;
        else                op = OP_UNUSED;
        case ($urandom_range(0, 9))
            0: x = 32'h0000_0000;
            1: x = SIGN_BIT;
            2: begin
                x = {1'($urandom_range(0, 1)), 8'hff, 23'($urandom)};
                if (x[22:0] == 23'h0) x[0] = 1'b1;
            end
            3: x = {1'($urandom_range(0, 1)), 8'hff, 23'h0};
            4: x = SIX_BITS + $urandom_range(0, 6) - 32'd3;
            5: x = {1'b1, 31'($urandom)};
            default: x = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: old = tag_word() | ($urandom & pm);
            4, 5:       old = ($urandom & ~lm) | tag_word() | ($urandom & pm);
            default:    old = $urandom;
        endcase
        send_beat(op, x, old);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                set_registers(5'd1, 5'd1, 31'h0, 32'h0, 1'b0, 31'h0);
            else if (ph == 1)
                set_registers(5'd31, 5'd31, 31'h7fff_ffff, 32'hffff_ffff, 1'b1, 31'h7fff_ffff);
            else
                random_settings();
            repeat (PHASE_BEATS) random_beat();
        end
    endtask

    initial begin
        win_bits     = RST_WINDOW;
        tag_bits     = RST_TAG_BITS;
        tag_val      = RST_TAG_VALUE;
        pay_inc      = RST_INCREMENT;
        patch_pos    = RST_PATCH_POS;
        seed_start_r = RST_SEED;
        seed_ctr     = 32'h0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (3) @(posedge aclk);

        test_default_corners();
        test_register_extremes();
        test_random_phases();

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("covered %0d input beats and %0d checked results over %0d register writes",
                 beats_sent, words_checked, reg_writes);
        $display("operations relu %0d, relu6 %0d, reseed %0d, unused %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
